// ===== hdl/rgbc_pkg.sv =====
// Shared types and constants for the RGB565 pixel compositor.
package rgbc_pkg;

  localparam int SW_BITS    = 12;
  localparam int PITCH_BITS = 13;
  localparam int CFG_BITS   = 13;
  localparam int PIX_BITS   = 16;
  localparam int OUT_ADDR_BITS = 24;

  typedef enum logic [1:0] {
    OP_OPAQUE = 2'd0,
    OP_BLEND  = 2'd1,
    OP_DARKEN = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic {
    REG_SURFACE_WIDTH = 1'b0,
    REG_ROW_PITCH     = 1'b1
  } reg_idx_t;

  localparam logic [SW_BITS-1:0]    SW_RESET    = 12'd480;
  localparam logic [PITCH_BITS-1:0] PITCH_RESET = 13'd480;

endpackage

// ===== hdl/rgb565_pixel_compositor.sv =====
// Top level of the RGB565 pixel compositor: registers, pipeline and checks.
//
// Per-pixel write stage for a framebuffer rotated by 90 degrees.
// Input channel: in_valid / in_stall with operation, x_pos, y_pos, source
// colour, alpha and the current destination pixel. Output channel:
// out_valid / out_stall with pixel_address, pixel_value and write_enable.
// A request is taken on an edge where valid is high and stall is low.
// Two stages: an input register, then the address multiply and the colour
// multiplies feed the result register. A request moves from the input
// register to the result register whenever the result register is free.
// Throughput is one pixel per cycle while out_stall is low: each register
// holds one request; x_pos * row_pitch and blend multiplies sit between.
// When the receiver stalls, the result register holds; the input register
// still takes one more request if it is empty, then in_stall rises.
// Reset clears both stage valids and loads surface_width and row_pitch
// with 480. Configuration via cfg_write/cfg_index/cfg_data while idle.
module rgb565_pixel_compositor
  import rgbc_pkg::*;
#(
  parameter int COORD_BITS = 11,
  parameter int ADDR_BITS  = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic [COORD_BITS-1:0]    x_pos,
  input  logic [COORD_BITS-1:0]    y_pos,
  input  logic [7:0]               src_red,
  input  logic [7:0]               src_green,
  input  logic [7:0]               src_blue,
  input  logic [7:0]               alpha,
  input  logic [PIX_BITS-1:0]      dest_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OUT_ADDR_BITS-1:0] pixel_address,
  output logic [PIX_BITS-1:0]      pixel_value,
  output logic                     write_enable
);

  logic [SW_BITS-1:0]    surface_width;
  logic [PITCH_BITS-1:0] row_pitch;

  // input register
  logic                  s1_valid;
  logic [1:0]            s1_op;
  logic [COORD_BITS-1:0] s1_x, s1_y;
  logic [7:0]            s1_r, s1_g, s1_b, s1_a;
  logic [PIX_BITS-1:0]   s1_dest;

  logic                  out_free;
  logic                  in_take;
  logic                  s1_move;

  logic [ADDR_BITS-1:0]  addr;
  logic                  s1_on_surface;
  logic [PIX_BITS-1:0]   s1_pixel;
  logic                  s1_colour_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width <= SW_RESET;
      row_pitch     <= PITCH_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SURFACE_WIDTH: surface_width <= cfg_data[SW_BITS-1:0];
        REG_ROW_PITCH:     row_pitch     <= cfg_data[PITCH_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op   <= operation;
      s1_x    <= x_pos;
      s1_y    <= y_pos;
      s1_r    <= src_red;
      s1_g    <= src_green;
      s1_b    <= src_blue;
      s1_a    <= alpha;
      s1_dest <= dest_pixel;
    end
  end

  rgbc_addr #(
    .COORD_BITS(COORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_addr (
    .x_pos        (s1_x),
    .y_pos        (s1_y),
    .surface_width(surface_width),
    .row_pitch    (row_pitch),
    .addr         (addr),
    .on_surface   (s1_on_surface)
  );

  rgbc_colour u_colour (
    .operation  (s1_op),
    .src_red    (s1_r),
    .src_green  (s1_g),
    .src_blue   (s1_b),
    .alpha      (s1_a),
    .dest_pixel (s1_dest),
    .pixel_value(s1_pixel),
    .colour_we  (s1_colour_we)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pixel_address <= OUT_ADDR_BITS'(addr);
      pixel_value   <= s1_pixel;
      write_enable  <= s1_colour_we && s1_on_surface;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  a_item_advances: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("request in input register failed to reach the output");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result appeared without a request behind it");

  a_outside_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_on_surface) |-> (addr == '0))
    else $error("out-of-surface pixel produced a non-zero address");

endmodule

// ===== hdl/rgbc_addr.sv =====
// Rotated framebuffer address generation and surface range check.
module rgbc_addr
  import rgbc_pkg::*;
#(
  parameter int COORD_BITS = 11,
  parameter int ADDR_BITS  = 24
) (
  input  logic [COORD_BITS-1:0] x_pos,
  input  logic [COORD_BITS-1:0] y_pos,
  input  logic [SW_BITS-1:0]    surface_width,
  input  logic [PITCH_BITS-1:0] row_pitch,
  output logic [ADDR_BITS-1:0]  addr,
  output logic                  on_surface
);

  localparam int CMP_W  = (COORD_BITS > SW_BITS) ? COORD_BITS : SW_BITS;
  localparam int PROD_W = COORD_BITS + PITCH_BITS + 1;

  logic [CMP_W-1:0]  y_ext;
  logic [CMP_W-1:0]  sw_ext;
  logic [CMP_W-1:0]  x_phys;
  logic [PROD_W-1:0] row_base;
  logic [PROD_W-1:0] sum;

  assign y_ext      = CMP_W'(y_pos);
  assign sw_ext     = CMP_W'(surface_width);
  assign on_surface = y_ext < sw_ext;
  // mirrored column; only meaningful on the surface
  assign x_phys = sw_ext - CMP_W'(1) - y_ext;

  assign row_base = PROD_W'(x_pos) * PROD_W'(row_pitch);
  assign sum      = row_base + PROD_W'(x_phys);

  assign addr = on_surface ? ADDR_BITS'(sum) : '0;

endmodule

// ===== hdl/rgbc_colour.sv =====
// RGB565 colour path: opaque pack, alpha blend and darken.
module rgbc_colour
  import rgbc_pkg::*;
(
  input  logic [1:0]          operation,
  input  logic [7:0]          src_red,
  input  logic [7:0]          src_green,
  input  logic [7:0]          src_blue,
  input  logic [7:0]          alpha,
  input  logic [PIX_BITS-1:0] dest_pixel,
  output logic [PIX_BITS-1:0] pixel_value,
  output logic                colour_we
);

  op_t         op;
  logic [4:0]  fg_r, fg_b, bg_r, bg_b;
  logic [5:0]  fg_g, bg_g;
  logic [7:0]  fg_w, inv_a;
  logic [13:0] sum_r, sum_b;
  logic [14:0] sum_g;
  logic [PIX_BITS-1:0] packed_src, mixed;

  assign op = op_t'(operation);

  assign fg_r = src_red[7:3];
  assign fg_g = src_green[7:2];
  assign fg_b = src_blue[7:3];
  assign bg_r = dest_pixel[15:11];
  assign bg_g = dest_pixel[10:5];
  assign bg_b = dest_pixel[4:0];

  assign packed_src = {fg_r, fg_g, fg_b};

  // darken is a blend against black, so the source weight drops to zero
  assign fg_w  = (op == OP_BLEND) ? alpha : 8'd0;
  assign inv_a = 8'd255 - alpha;

  assign sum_r = 14'(fg_r) * 14'(fg_w) + 14'(bg_r) * 14'(inv_a);
  assign sum_g = 15'(fg_g) * 15'(fg_w) + 15'(bg_g) * 15'(inv_a);
  assign sum_b = 14'(fg_b) * 14'(fg_w) + 14'(bg_b) * 14'(inv_a);

  assign mixed = {sum_r[12:8], sum_g[13:8], sum_b[12:8]};

  always_comb begin
    unique case (op) inside
      OP_OPAQUE: begin
        pixel_value = packed_src;
        colour_we   = 1'b1;
      end
      OP_BLEND, OP_DARKEN: begin
        pixel_value = mixed;
        colour_we   = alpha != 8'd0;
      end
      default: begin
        pixel_value = dest_pixel;
        colour_we   = 1'b0;
      end
    endcase
  end

endmodule

// ===== tb/rgb565_write_checker.sv =====
// Checker for the pixel compositor: predicts each pixel write and compares the results.
`timescale 1ns / 100ps

module rgb565_write_checker
  import rgbc_pkg::*;
#(
  parameter int COORD_BITS = 11,
  parameter int ADDR_BITS  = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               operation,
  input  logic [COORD_BITS-1:0]    x_pos,
  input  logic [COORD_BITS-1:0]    y_pos,
  input  logic [7:0]               src_red,
  input  logic [7:0]               src_green,
  input  logic [7:0]               src_blue,
  input  logic [7:0]               alpha,
  input  logic [PIX_BITS-1:0]      dest_pixel,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [OUT_ADDR_BITS-1:0] pixel_address,
  input  logic [PIX_BITS-1:0]      pixel_value,
  input  logic                     write_enable,
  output int                       fail_count,
  output int                       pending_count
);

  typedef struct packed {
    logic [OUT_ADDR_BITS-1:0] addr;
    logic [PIX_BITS-1:0]      value;
    logic                     we;
  } pixel_write_t;

  localparam int REPORT_LIMIT = 10;

  logic [SW_BITS-1:0]    surf_width;
  logic [PITCH_BITS-1:0] pitch;
  pixel_write_t          expected_writes[$];

  // per channel (fg*fg_w + bg*bg_w) >> 8 on the 5/6/5 fields
  function automatic logic [PIX_BITS-1:0] weigh_565(logic [15:0] bg, logic [15:0] fg,
                                                     logic [7:0] fg_w, logic [7:0] bg_w);
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    r = (32'(fg[15:11]) * fg_w + 32'(bg[15:11]) * bg_w) >> 8;
    g = (32'(fg[10:5]) * fg_w + 32'(bg[10:5]) * bg_w) >> 8;
    b = (32'(fg[4:0]) * fg_w + 32'(bg[4:0]) * bg_w) >> 8;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic pixel_write_t composite_pixel(op_t op, logic [COORD_BITS-1:0] x,
                                                   logic [COORD_BITS-1:0] y,
                                                   logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b, logic [7:0] a,
                                                   logic [15:0] bg);
    pixel_write_t w;
    logic [15:0]  fg;
    logic [7:0]   inv;
    logic [63:0]  addr;
    logic         on_surface;
    fg         = {r[7:3], g[7:2], b[7:3]};
    inv        = 8'd255 - a;
    on_surface = 32'(y) < 32'(surf_width);
    addr       = '0;
    if (on_surface) begin
      addr = 64'(x) * 64'(pitch) + 64'(surf_width) - 64'd1 - 64'(y);
      addr = addr & ((64'd1 << ADDR_BITS) - 64'd1);
    end
    w.addr = addr[OUT_ADDR_BITS-1:0];
    case (op)
      OP_OPAQUE: begin
        w.value = fg;
        w.we    = 1'b1;
      end
      OP_BLEND: begin
        w.value = weigh_565(bg, fg, a, inv);
        w.we    = a != 8'd0;
      end
      OP_DARKEN: begin
        w.value = weigh_565(bg, 16'h0000, 8'd0, inv);
        w.we    = a != 8'd0;
      end
      default: begin
        w.value = bg;
        w.we    = 1'b0;
      end
    endcase
    if (!on_surface) w.we = 1'b0;
    return w;
  endfunction

  task automatic note_failure(string what, pixel_write_t want, pixel_write_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t %s: expected addr %h value %h we %b, got addr %h value %h we %b",
               $realtime, what, want.addr, want.value, want.we,
               got.addr, got.value, got.we);
  endtask

  always @(posedge clk) begin
    pixel_write_t want;
    pixel_write_t got;
    if (rst) begin
      surf_width = SW_RESET;
      pitch      = PITCH_RESET;
      fail_count = 0;
      expected_writes.delete();
    end else begin
      // results first, so a stray one never meets a request taken on this edge
      if (out_valid && !out_stall) begin
        got = '{pixel_address, pixel_value, write_enable};
        if (expected_writes.size() == 0) begin
          note_failure("unrequested pixel write", '0, got);
        end else begin
          want = expected_writes.pop_front();
          if (got.addr !== want.addr || got.value !== want.value || got.we !== want.we)
            note_failure("pixel write mismatch", want, got);
        end
      end
      if (in_valid && !in_stall)
        expected_writes.push_back(composite_pixel(op_t'(operation), x_pos, y_pos, src_red,
                                                  src_green, src_blue, alpha, dest_pixel));
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_SURFACE_WIDTH: surf_width = cfg_data[SW_BITS-1:0];
          REG_ROW_PITCH:     pitch      = cfg_data[PITCH_BITS-1:0];
        endcase
      end
    end
    pending_count = expected_writes.size();
  end

endmodule

// ===== tb/rgb565_pixel_compositor_test.sv =====
// Testbench top for the pixel compositor: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module rgb565_pixel_compositor_test;
  import rgbc_pkg::*;

  localparam int COORD_BITS   = 11;
  localparam int ADDR_BITS    = 24;
  localparam int PHASE_ITEMS  = 105;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic                     cfg_index = 1'b0;
  logic [CFG_BITS-1:0]      cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               operation = '0;
  logic [COORD_BITS-1:0]    x_pos = '0;
  logic [COORD_BITS-1:0]    y_pos = '0;
  logic [7:0]               src_red = '0;
  logic [7:0]               src_green = '0;
  logic [7:0]               src_blue = '0;
  logic [7:0]               alpha = '0;
  logic [PIX_BITS-1:0]      dest_pixel = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [OUT_ADDR_BITS-1:0] pixel_address;
  logic [PIX_BITS-1:0]      pixel_value;
  logic                     write_enable;

  int          fail_count;
  int          pending_count;
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          hold_request = 1'b0;
  logic [11:0] cur_width = SW_RESET;

  rgb565_pixel_compositor #(
    .COORD_BITS(COORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .src_red      (src_red),
    .src_green    (src_green),
    .src_blue     (src_blue),
    .alpha        (alpha),
    .dest_pixel   (dest_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_address(pixel_address),
    .pixel_value  (pixel_value),
    .write_enable (write_enable)
  );

  rgb565_write_checker #(
    .COORD_BITS(COORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .src_red      (src_red),
    .src_green    (src_green),
    .src_blue     (src_blue),
    .alpha        (alpha),
    .dest_pixel   (dest_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_address(pixel_address),
    .pixel_value  (pixel_value),
    .write_enable (write_enable),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Entered and left at a rising edge; returns on the edge that takes the request.
  task automatic send_pixel(op_t op, logic [10:0] x, logic [10:0] y, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b, logic [7:0] a, logic [15:0] bg);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    x_pos      <= x;
    y_pos      <= y;
    src_red    <= r;
    src_green  <= g;
    src_blue   <= b;
    alpha      <= a;
    dest_pixel <= bg;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_pixel();
    op_t         op;
    logic [10:0] x;
    logic [10:0] y;
    logic [7:0]  a;
    logic [11:0] top_y;
    int          pick;
    pick = $urandom_range(0, 99);
    op   = (pick < 8) ? OP_UNUSED : op_t'($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    x    = (pick == 0) ? 11'd0 : (pick == 1) ? 11'h7FF : 11'($urandom);
    pick = $urandom_range(0, 9);
    a    = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    // bias y towards the surface edge and inside it
    top_y = (cur_width > 12'd2048) ? 12'd2047 : cur_width - 12'd1;
    pick  = $urandom_range(0, 9);
    if (pick == 0 && cur_width <= 12'd2047)
      y = cur_width[10:0];
    else if (pick == 1 && cur_width != 12'd0)
      y = top_y[10:0];
    else if (pick == 2)
      y = $urandom_range(0, 1) ? 11'h7FF : 11'd0;
    else if (pick == 3 || cur_width == 12'd0)
      y = 11'($urandom);
    else
      y = 11'($urandom_range(0, top_y));
    send_pixel(op, x, y, 8'($urandom), 8'($urandom), 8'($urandom), a, 16'($urandom));
  endtask

  // Wait until every expected write has come out, then let the pipeline settle.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_BITS-1:0] width, logic [CFG_BITS-1:0] row_pitch);
    cfg_write <= 1'b1;
    cfg_index <= REG_SURFACE_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= REG_ROW_PITCH;
    cfg_data  <= row_pitch;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_width = width[11:0];
  endtask

  initial begin : stimulus
    logic [CFG_BITS-1:0] width;
    logic [CFG_BITS-1:0] row_pitch;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pixels at the reset geometry
    gap_pct   = 10;
    stall_pct = 10;
    send_pixel(OP_OPAQUE, 11'd0, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_pixel(OP_OPAQUE, 11'h7FF, 11'd479, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_pixel(OP_OPAQUE, 11'd100, 11'd480, 8'hA7, 8'h5B, 8'hC3, 8'h10, 16'h1234);
    send_pixel(OP_OPAQUE, 11'd5, 11'h7FF, 8'h12, 8'h34, 8'h56, 8'h78, 16'h9ABC);
    send_pixel(OP_OPAQUE, 11'd1023, 11'd240, 8'h07, 8'h03, 8'h07, 8'h00, 16'h0000);
    send_pixel(OP_BLEND, 11'd10, 11'd20, 8'hFF, 8'hFF, 8'hFF, 8'h00, 16'h0000);
    send_pixel(OP_BLEND, 11'd10, 11'd20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
    send_pixel(OP_BLEND, 11'd11, 11'd21, 8'h00, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
    send_pixel(OP_BLEND, 11'd12, 11'd22, 8'hFF, 8'h00, 8'hFF, 8'h80, 16'h07E0);
    send_pixel(OP_BLEND, 11'd13, 11'd23, 8'h3C, 8'hC3, 8'h81, 8'h01, 16'hFFFF);
    send_pixel(OP_BLEND, 11'h7FF, 11'd0, 8'hFF, 8'hFF, 8'hFF, 8'hC8, 16'hFFFF);
    send_pixel(OP_BLEND, 11'd3, 11'd480, 8'h80, 8'h40, 8'h20, 8'h63, 16'h5555);
    send_pixel(OP_DARKEN, 11'd0, 11'd479, 8'hFF, 8'hFF, 8'hFF, 8'h00, 16'hFFFF);
    send_pixel(OP_DARKEN, 11'd1, 11'd1, 8'h00, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
    send_pixel(OP_DARKEN, 11'd2, 11'd2, 8'hAA, 8'h55, 8'hAA, 8'h01, 16'hFFFF);
    send_pixel(OP_DARKEN, 11'd3, 11'd3, 8'h55, 8'hAA, 8'h55, 8'h80, 16'hA5A5);
    send_pixel(OP_DARKEN, 11'd4, 11'd4, 8'hFF, 8'h00, 8'hFF, 8'h40, 16'h0000);
    send_pixel(OP_UNUSED, 11'd7, 11'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hA5A5);
    send_pixel(OP_UNUSED, 11'h7FF, 11'h7FF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h5A5A);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin width = 13'd4095; row_pitch = 13'd8191; end
        1: begin width = 13'd1;    row_pitch = 13'd1;    end
        2: begin width = 13'd0;    row_pitch = 13'd0;    end
        3: begin width = 13'd2048; row_pitch = 13'd4096; end
        4: begin width = 13'd1;    row_pitch = 13'd8191; end
        5: begin width = 13'($urandom); row_pitch = 13'($urandom); end
        default: begin
          width     = 13'($urandom_range(1, 2048));
          row_pitch = 13'($urandom_range(1, 4096));
        end
      endcase
      set_config(width, row_pitch);
      if (ph == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = (ph % 3 == 2) ? 0 : 15;
        stall_pct = (ph % 2 == 0) ? 25 : 5;
      end
      // the receiver holds off long enough for the input side to back up
      if (ph == 3) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_random_pixel();
    end

    settle();
    if (fail_count == 0)
      $display("PASS rgb565_pixel_compositor");
    else
      $display("FAIL rgb565_pixel_compositor");
    $finish;
  end

  initial begin : receive_side
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL rgb565_pixel_compositor");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rgbc_pkg.sv
hdl/rgbc_addr.sv
hdl/rgbc_colour.sv
hdl/rgb565_pixel_compositor.sv
tb/rgb565_write_checker.sv
tb/rgb565_pixel_compositor_test.sv
